### sv/giophp_pkg.sv
// Shared types and constants for the GIOP/ZIOP message header parser.
// Used by giop_header_parser and its port checker; no dependencies.
`timescale 1ns / 1ps

package giophp_pkg;

	// Header layout
	localparam int HEADER_BYTES = 12;
	localparam int POS_W        = 4;
	localparam logic [POS_W-1:0] POS_MAGIC0 = POS_W'(0);
	localparam logic [POS_W-1:0] POS_MAGIC1 = POS_W'(1);
	localparam logic [POS_W-1:0] POS_MAGIC2 = POS_W'(2);
	localparam logic [POS_W-1:0] POS_MAGIC3 = POS_W'(3);
	localparam logic [POS_W-1:0] POS_MAJOR  = POS_W'(4);
	localparam logic [POS_W-1:0] POS_MINOR  = POS_W'(5);
	localparam logic [POS_W-1:0] POS_FLAGS  = POS_W'(6);
	localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(7);
	localparam logic [POS_W-1:0] POS_LAST   = POS_W'(HEADER_BYTES - 1);

	// Magic bytes
	localparam logic [7:0] MAGIC_Z = 8'h5A;
	localparam logic [7:0] MAGIC_G = 8'h47;
	localparam logic [7:0] MAGIC_I = 8'h49;
	localparam logic [7:0] MAGIC_O = 8'h4F;
	localparam logic [7:0] MAGIC_P = 8'h50;

	// Message types that may carry an empty body
	localparam logic [7:0] MSG_CLOSE_CONNECTION = 8'd5;
	localparam logic [7:0] MSG_MESSAGE_ERROR    = 8'd6;

	// Version 1.0 special handling
	localparam logic [7:0] V10_MAJOR = 8'd1;
	localparam logic [7:0] V10_MINOR = 8'd0;

	// Flags bits
	localparam int FLAG_LITTLE_ENDIAN = 0;
	localparam int FLAG_MORE_FRAGS    = 1;

	// Configuration registers
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_ACCEPTED_MAJOR = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_MINOR      = 1'b1;
	localparam logic [7:0] ACCEPTED_MAJOR_RST = 8'd1;
	localparam logic [7:0] MAX_MINOR_RST      = 8'd2;

	typedef enum logic [2:0] {
		ST_OK             = 3'd0,
		ST_NEED_MORE      = 3'd1,
		ST_BAD_MAGIC      = 3'd2,
		ST_BAD_VERSION    = 3'd3,
		ST_BAD_BYTE_ORDER = 3'd4,
		ST_ZERO_SIZE      = 3'd5
	} status_t;

	// Result word, status field in the lowest bits, padded to 64 bits
	typedef struct packed {
		logic [1:0]  pad;
		logic        compressed;
		logic        more_fragments;
		logic        little_endian;
		logic [7:0]  version_minor;
		logic [7:0]  version_major;
		logic [31:0] payload_size;
		logic [7:0]  message_type;
		status_t     status;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

### sv/giop_header_parser.sv
// GIOP/ZIOP message header parser: one header byte per word in, one result
// word per header out. Depends on giophp_pkg.
`timescale 1ns / 1ps
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata = header_byte, s_tlast = end_of_data
//  m_*       out  m_tvalid/m_tready   m_tdata = result_t (status .. compressed)
//  cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
//  One byte per cycle sustained while results are taken. A byte is registered in
//  the input stage, then decoded against the running header state in the next
//  cycle; a result enters the output register as its last byte leaves the input
//  stage. The input stage only waits when it holds a result-ending byte and the
//  output register is full and not being taken. Reset clears the header position
//  and error, sets accepted_major to 1, max_minor to 2. cfg_ready is always high.

module giop_header_parser
	import giophp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data,
	// header byte stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] header_byte
	input  logic                   s_tlast,   // end_of_data
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [RESULT_W-1:0]    m_tdata    // [2:0] status, [10:3] message_type,
	                                          // [42:11] payload_size, [50:43] version_major,
	                                          // [58:51] version_minor, [59] little_endian,
	                                          // [60] more_fragments, [61] compressed, [63:62] 0
);

	// Configuration registers
	logic [7:0] accepted_major_q;
	logic [7:0] max_minor_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Running header state
	logic [POS_W-1:0] count_q;
	status_t          err_q;
	logic             zmagic_q;
	logic [7:0]       major_q;
	logic [7:0]       minor_q;
	logic [1:0]       flags_q;
	logic [7:0]       type_q;
	logic [23:0]      size_q;

	// Output register
	logic    out_valid_q;
	result_t out_data_q;

	// Decode signals
	logic    produce;
	logic    out_free;
	logic    advance;
	status_t chk;
	status_t new_err;
	logic [31:0] size_be;
	logic [31:0] size_dec;
	logic    v10;
	result_t result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_major_q <= ACCEPTED_MAJOR_RST;
			max_minor_q      <= MAX_MINOR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ACCEPTED_MAJOR: accepted_major_q <= cfg_data;
				REG_MAX_MINOR:      max_minor_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Flow control
	assign produce  = valid_s1 && (last_s1 || count_q == POS_LAST);
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!produce || out_free);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Size as it stands once the last byte is in
	assign size_be  = {size_q, byte_s1};
	assign size_dec = flags_q[FLAG_LITTLE_ENDIAN]
		? {byte_s1, size_q[7:0], size_q[15:8], size_q[23:16]}
		: size_be;
	assign v10 = (major_q == V10_MAJOR) && (minor_q == V10_MINOR);

	// Per-position check of the current byte
	always_comb begin
		chk = ST_OK;
		unique case (count_q)
			POS_MAGIC0: if (byte_s1 != MAGIC_Z && byte_s1 != MAGIC_G) chk = ST_BAD_MAGIC;
			POS_MAGIC1: if (byte_s1 != MAGIC_I) chk = ST_BAD_MAGIC;
			POS_MAGIC2: if (byte_s1 != MAGIC_O) chk = ST_BAD_MAGIC;
			POS_MAGIC3: if (byte_s1 != MAGIC_P) chk = ST_BAD_MAGIC;
			POS_MINOR: begin
				if (major_q != accepted_major_q || byte_s1 > max_minor_q)
					chk = ST_BAD_VERSION;
			end
			POS_FLAGS: begin
				if (major_q == V10_MAJOR && minor_q == V10_MINOR && byte_s1 > 8'd1)
					chk = ST_BAD_BYTE_ORDER;
			end
			POS_LAST: begin
				if (size_dec == 32'd0 && type_q != MSG_CLOSE_CONNECTION
						&& type_q != MSG_MESSAGE_ERROR)
					chk = ST_ZERO_SIZE;
			end
			default: chk = ST_OK;
		endcase
	end

	// First error in check order wins
	assign new_err = (err_q != ST_OK) ? err_q : chk;

	// Result word
	always_comb begin
		result = '0;
		if (count_q != POS_LAST) begin
			result.status = ST_NEED_MORE;
		end else begin
			result.status = new_err;
			if (new_err == ST_OK) begin
				result.message_type   = type_q;
				result.payload_size   = size_dec;
				result.version_major  = major_q;
				result.version_minor  = minor_q;
				result.little_endian  = flags_q[FLAG_LITTLE_ENDIAN];
				result.more_fragments = !v10 && flags_q[FLAG_MORE_FRAGS];
				result.compressed     = !v10 && zmagic_q;
			end
		end
	end

	// Header control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= ST_OK;
		end else if (advance) begin
			if (produce) begin
				count_q <= '0;
				err_q   <= ST_OK;
			end else begin
				count_q <= count_q + POS_W'(1);
				err_q   <= new_err;
			end
		end
	end

	// Header fields, each written at its own position before use
	always_ff @(posedge clk) begin
		if (advance) begin
			unique case (count_q)
				POS_MAGIC0: zmagic_q <= (byte_s1 == MAGIC_Z);
				POS_MAJOR:  major_q  <= byte_s1;
				POS_MINOR:  minor_q  <= byte_s1;
				POS_FLAGS:  flags_q  <= byte_s1[1:0];
				POS_TYPE:   type_q   <= byte_s1;
				default:    size_q   <= {size_q[15:0], byte_s1};
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && produce) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### sv/giophp_checker.sv
// Port-level checker for giop_header_parser, bound into every instance of it.
// Depends on giophp_pkg.
`timescale 1ns / 1ps

module giophp_checker
	import giophp_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [7:0]             cfg_data,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [7:0]             s_tdata,
	input logic                   s_tlast,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [RESULT_W-1:0]    m_tdata
);

	result_t res;
	assign res = result_t'(m_tdata);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// A failed header reports nothing but its status
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.status != ST_OK |-> m_tdata[RESULT_W-1:3] == '0)
		else $error("non-ok result carries field data");

	// An empty body passes only for CloseConnection or MessageError
	a_zero_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.status == ST_OK && res.payload_size == 32'd0 |->
		res.message_type == MSG_CLOSE_CONNECTION || res.message_type == MSG_MESSAGE_ERROR)
		else $error("zero size passed for wrong message type");

	// Version 1.0 has no fragment or compression marks
	a_v10_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.status == ST_OK && res.version_major == V10_MAJOR
		&& res.version_minor == V10_MINOR |-> !res.more_fragments && !res.compressed)
		else $error("version 1.0 result with fragment or compression flag");

	// A fresh result follows a byte taken through the input stage
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a preceding input byte");

endmodule

bind giop_header_parser giophp_checker u_giophp_checker (.*);

### sim/tb_giop_header_parser.sv
// Self-checking testbench for giop_header_parser: directed header words, then
// random headers under several register settings, each checked against a predictor.
// Depends on giophp_pkg and giop_header_parser.
`timescale 1ns / 1ps

module tb_giop_header_parser;
	import giophp_pkg::*;

	localparam int N_PHASES      = 6;
	localparam int PHASE_BYTES   = 232;
	localparam int SETTLE_CYCLES = 6;
	// no word moves for this long: far beyond any 60% stall run plus the pipeline
	localparam int STALL_LIMIT   = 1000;

	// directed rows: where the result is obvious it is typed in, else predicted
	typedef enum logic [1:0] {
		KNOWN_NONE,
		KNOWN_NEED_MORE,
		KNOWN_OK_MAX,
		KNOWN_BAD_ORDER
	} known_t;

	typedef struct packed {
		logic [7:0] hdr_byte;
		logic       eod;
		known_t     known;
	} stim_row_t;

	localparam int N_DIRECTED = 26;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// early end after a bad magic byte still gives need_more
		'{8'h00, 1'b0, KNOWN_NONE},
		'{8'hFF, 1'b1, KNOWN_NEED_MORE},
		// ZIOP 1.2, all flags set, max type and size, end on the last byte
		'{MAGIC_Z, 1'b0, KNOWN_NONE},
		'{MAGIC_I, 1'b0, KNOWN_NONE},
		'{MAGIC_O, 1'b0, KNOWN_NONE},
		'{MAGIC_P, 1'b0, KNOWN_NONE},
		'{8'h01, 1'b0, KNOWN_NONE},
		'{8'h02, 1'b0, KNOWN_NONE},
		'{8'h03, 1'b0, KNOWN_NONE},
		'{8'hFF, 1'b0, KNOWN_NONE},
		'{8'hFF, 1'b0, KNOWN_NONE},
		'{8'hFF, 1'b0, KNOWN_NONE},
		'{8'hFF, 1'b0, KNOWN_NONE},
		'{8'hFF, 1'b1, KNOWN_OK_MAX},
		// GIOP 1.0 with flags 2: byte order error wins over the zero size
		'{MAGIC_G, 1'b0, KNOWN_NONE},
		'{MAGIC_I, 1'b0, KNOWN_NONE},
		'{MAGIC_O, 1'b0, KNOWN_NONE},
		'{MAGIC_P, 1'b0, KNOWN_NONE},
		'{8'h01, 1'b0, KNOWN_NONE},
		'{8'h00, 1'b0, KNOWN_NONE},
		'{8'h02, 1'b0, KNOWN_NONE},
		'{8'h00, 1'b0, KNOWN_NONE},
		'{8'h00, 1'b0, KNOWN_NONE},
		'{8'h00, 1'b0, KNOWN_NONE},
		'{8'h00, 1'b0, KNOWN_NONE},
		'{8'h00, 1'b0, KNOWN_BAD_ORDER}
	};

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [7:0]             cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata   = '0;   // [7:0] header_byte
	logic                   s_tlast   = 1'b0; // end_of_data
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [RESULT_W-1:0]    m_tdata;          // [2:0] status, [10:3] message_type,
	                                          // [42:11] payload_size, [50:43] version_major,
	                                          // [58:51] version_minor, [59] little_endian,
	                                          // [60] more_fragments, [61] compressed

	giop_header_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #6 clk = ~clk;

	// predictor copy of the registers and the running header
	logic [7:0]       cfg_major     = ACCEPTED_MAJOR_RST;
	logic [7:0]       cfg_minor_max = MAX_MINOR_RST;
	logic [POS_W-1:0] hdr_pos;
	logic [7:0]       magic_first;
	status_t          err_seen;
	logic [7:0]       ver_major;
	logic [7:0]       ver_minor;
	logic [7:0]       flag_byte;
	logic [7:0]       msg_type;
	logic [31:0]      size_shift;

	result_t header_results_due [$];
	int      mismatches  = 0;
	int      tx_idle_pct = 10;
	int      rx_idle_pct = 60;
	int      quiet_cycles = 0;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	task automatic clear_header();
		hdr_pos     = '0;
		magic_first = '0;
		err_seen    = ST_OK;
		ver_major   = '0;
		ver_minor   = '0;
		flag_byte   = '0;
		msg_type    = '0;
		size_shift  = '0;
	endtask

	task automatic note_status(input status_t code);
		if (err_seen == ST_OK)
			err_seen = code;
	endtask

	// one header byte through the predictor; done marks a result
	task automatic parse_header_byte(input logic [7:0] b, input logic eod,
			output logic done, output result_t res);
		logic        v10;
		logic        le;
		logic [31:0] size;
		res  = '0;
		done = 1'b0;
		case (hdr_pos)
			POS_MAGIC0: begin
				magic_first = b;
				if (b != MAGIC_Z && b != MAGIC_G)
					note_status(ST_BAD_MAGIC);
			end
			POS_MAGIC1: if (b != MAGIC_I) note_status(ST_BAD_MAGIC);
			POS_MAGIC2: if (b != MAGIC_O) note_status(ST_BAD_MAGIC);
			POS_MAGIC3: if (b != MAGIC_P) note_status(ST_BAD_MAGIC);
			POS_MAJOR:  ver_major = b;
			POS_MINOR: begin
				ver_minor = b;
				if (ver_major != cfg_major || b > cfg_minor_max)
					note_status(ST_BAD_VERSION);
			end
			POS_FLAGS: begin
				flag_byte = b;
				if (ver_major == V10_MAJOR && ver_minor == V10_MINOR && b > 8'd1)
					note_status(ST_BAD_BYTE_ORDER);
			end
			POS_TYPE: msg_type = b;
			default:  size_shift = {size_shift[23:0], b};
		endcase

		if (hdr_pos != POS_LAST) begin
			if (eod) begin
				res.status = ST_NEED_MORE;
				done = 1'b1;
				clear_header();
			end else begin
				hdr_pos = hdr_pos + POS_W'(1);
			end
		end else begin
			v10  = (ver_major == V10_MAJOR && ver_minor == V10_MINOR);
			le   = flag_byte[FLAG_LITTLE_ENDIAN];
			size = le ? {size_shift[7:0], size_shift[15:8], size_shift[23:16],
				size_shift[31:24]} : size_shift;
			if (size == 32'd0 && msg_type != MSG_CLOSE_CONNECTION &&
					msg_type != MSG_MESSAGE_ERROR)
				note_status(ST_ZERO_SIZE);
			res.status = err_seen;
			if (err_seen == ST_OK) begin
				res.message_type   = msg_type;
				res.payload_size   = size;
				res.version_major  = ver_major;
				res.version_minor  = ver_minor;
				res.little_endian  = le;
				res.more_fragments = v10 ? 1'b0 : flag_byte[FLAG_MORE_FRAGS];
				res.compressed     = v10 ? 1'b0 : (magic_first == MAGIC_Z);
			end
			done = 1'b1;
			clear_header();
		end
	endtask

	// entered at a falling edge; valid stays high until the next word or idle
	task automatic send_byte(input logic [7:0] b, input logic eod,
			input logic use_known, input result_t known);
		logic    done;
		result_t pred;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eod;
		do @(posedge clk); while (!s_tready);
		parse_header_byte(b, eod, done, pred);
		if (done)
			header_results_due.push_back(use_known ? known : pred);
		@(negedge clk);
	endtask

	// one header: mostly well formed with random content, sometimes noise
	task automatic send_header(output int sent);
		logic [7:0]  hb [HEADER_BYTES];
		logic [31:0] sz;
		logic        eod;
		int          cut;
		int          r;
		if ($urandom_range(99) < 5) begin
			for (int k = 0; k < HEADER_BYTES; k++) begin
				send_byte(8'($urandom), ($urandom_range(9) == 0), 1'b0, '0);
			end
			sent = HEADER_BYTES;
		end else begin
			r = $urandom_range(99);
			hb[0] = (r < 45) ? MAGIC_G : (r < 90) ? MAGIC_Z : 8'($urandom);
			hb[1] = ($urandom_range(99) < 95) ? MAGIC_I : 8'($urandom);
			hb[2] = ($urandom_range(99) < 95) ? MAGIC_O : 8'($urandom);
			hb[3] = ($urandom_range(99) < 95) ? MAGIC_P : 8'($urandom);
			hb[4] = ($urandom_range(99) < 80) ? cfg_major : 8'($urandom);
			r = $urandom_range(99);
			if (r < 60)
				hb[5] = 8'($urandom_range(cfg_minor_max));
			else
				hb[5] = 8'($urandom);
			// version 1.0 gets its own share
			if ($urandom_range(99) < 15) begin
				hb[4] = V10_MAJOR;
				hb[5] = V10_MINOR;
			end
			hb[6] = ($urandom_range(1) != 0) ? 8'($urandom_range(3)) : 8'($urandom);
			r = $urandom_range(99);
			if (r < 30)
				hb[7] = ($urandom_range(1) != 0) ? MSG_CLOSE_CONNECTION : MSG_MESSAGE_ERROR;
			else if (r < 60)
				hb[7] = 8'($urandom_range(7));
			else
				hb[7] = 8'($urandom);
			r = $urandom_range(99);
			sz = (r < 25) ? 32'd0 : (r < 35) ? 32'hFFFF_FFFF : 32'($urandom);
			{hb[8], hb[9], hb[10], hb[11]} = sz;
			cut = ($urandom_range(99) < 10) ? $urandom_range(HEADER_BYTES - 2) :
				HEADER_BYTES - 1;
			for (int k = 0; k <= cut; k++) begin
				if (k < cut)
					eod = 1'b0;
				else if (cut < HEADER_BYTES - 1)
					eod = 1'b1;
				else
					eod = 1'($urandom_range(1));
				send_byte(hb[k], eod, 1'b0, '0);
			end
			sent = cut + 1;
		end
	endtask

	// hold the sender until every result is in and the pipeline is empty
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (header_results_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write; the caller lowers cfg_valid after the last one
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_ACCEPTED_MAJOR)
			cfg_major = val;
		else
			cfg_minor_max = val;
		@(negedge clk);
	endtask

	// receiver backpressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// result checker
	result_t got_res;
	result_t want_res;
	string   diffs;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res = m_tdata;
			if (header_results_due.size() == 0) begin
				report_mismatch($sformatf("result word %h with none expected", m_tdata));
			end else begin
				want_res = header_results_due.pop_front();
				diffs = "";
				if (got_res.status !== want_res.status)
					diffs = {diffs, $sformatf(" status %0d/%0d",
						got_res.status, want_res.status)};
				if (got_res.message_type !== want_res.message_type)
					diffs = {diffs, $sformatf(" type %h/%h",
						got_res.message_type, want_res.message_type)};
				if (got_res.payload_size !== want_res.payload_size)
					diffs = {diffs, $sformatf(" size %h/%h",
						got_res.payload_size, want_res.payload_size)};
				if (got_res.version_major !== want_res.version_major)
					diffs = {diffs, $sformatf(" major %h/%h",
						got_res.version_major, want_res.version_major)};
				if (got_res.version_minor !== want_res.version_minor)
					diffs = {diffs, $sformatf(" minor %h/%h",
						got_res.version_minor, want_res.version_minor)};
				if (got_res.little_endian !== want_res.little_endian)
					diffs = {diffs, $sformatf(" le %b/%b",
						got_res.little_endian, want_res.little_endian)};
				if (got_res.more_fragments !== want_res.more_fragments)
					diffs = {diffs, $sformatf(" frag %b/%b",
						got_res.more_fragments, want_res.more_fragments)};
				if (got_res.compressed !== want_res.compressed)
					diffs = {diffs, $sformatf(" comp %b/%b",
						got_res.compressed, want_res.compressed)};
				if (diffs != "")
					report_mismatch({"result (got/want):", diffs});
			end
		end
	end

	// watchdog on cycles where no word moves on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// stimulus
	initial begin
		int      sent;
		int      phase_bytes;
		int      hdrs;
		result_t known;
		clear_header();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed table
		for (int i = 0; i < N_DIRECTED; i++) begin
			known = '0;
			case (directed_rows[i].known)
				KNOWN_NEED_MORE: known.status = ST_NEED_MORE;
				KNOWN_BAD_ORDER: known.status = ST_BAD_BYTE_ORDER;
				KNOWN_OK_MAX: begin
					known.status         = ST_OK;
					known.message_type   = 8'hFF;
					known.payload_size   = 32'hFFFF_FFFF;
					known.version_major  = 8'd1;
					known.version_minor  = 8'd2;
					known.little_endian  = 1'b1;
					known.more_fragments = 1'b1;
					known.compressed     = 1'b1;
				end
				default: known = '0;
			endcase
			send_byte(directed_rows[i].hdr_byte, directed_rows[i].eod,
				directed_rows[i].known != KNOWN_NONE, known);
		end

		// random phases, each with its own register setting; the idle mix changes every two phases
		for (int p = 0; p < N_PHASES; p++) begin
			if (p < 2) begin
				tx_idle_pct = 10;
				rx_idle_pct = 60;
			end else if (p < 4) begin
				tx_idle_pct = 60;
				rx_idle_pct = 10;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (p != 0) begin
				drain_results();
				case (p)
					1: begin
						write_reg(REG_ACCEPTED_MAJOR, 8'd0);
						write_reg(REG_MAX_MINOR, 8'd0);
					end
					2: begin
						write_reg(REG_ACCEPTED_MAJOR, 8'hFF);
						write_reg(REG_MAX_MINOR, 8'hFF);
					end
					3: begin
						write_reg(REG_ACCEPTED_MAJOR, V10_MAJOR);
						write_reg(REG_MAX_MINOR, V10_MINOR);
					end
					4: begin
						write_reg(REG_ACCEPTED_MAJOR, V10_MAJOR);
						write_reg(REG_MAX_MINOR, 8'hFF);
					end
					default: begin
						write_reg(REG_ACCEPTED_MAJOR, 8'($urandom));
						write_reg(REG_MAX_MINOR, 8'($urandom));
					end
				endcase
				cfg_valid <= 1'b0;
			end
			phase_bytes = 0;
			hdrs = 0;
			while (phase_bytes < PHASE_BYTES) begin
				send_header(sent);
				phase_bytes += sent;
				hdrs++;
				// sender waits for the output to run dry once per phase
				if (hdrs == 8)
					drain_results();
			end
		end

		drain_results();
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### sim.f
sv/giophp_pkg.sv
sv/giop_header_parser.sv
sv/giophp_checker.sv
sim/tb_giop_header_parser.sv
